[hdl/assert_macros.svh]
// Assertion helpers used by the ssc_props checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SSC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SSC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/ssc_pkg.sv]
package ssc_pkg;

   // CORDIC angle constants, Q3.30
   localparam logic signed [33:0] ANG_PI          = 34'sd3373259426;
   localparam logic signed [33:0] ANG_HALF_PI     = 34'sd1686629713;
   localparam logic signed [63:0] CORDIC_INV_GAIN = 64'sd652032874;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_PROPORTIONAL_GAIN = 3'd0;
   localparam logic [2:0] REG_SOFTENING_GAIN    = 3'd1;
   localparam logic [2:0] REG_DERIVATIVE_GAIN   = 3'd2;
   localparam logic [2:0] REG_STEERING_LIMIT    = 3'd3;
   localparam logic [2:0] REG_LOOP_RATE_HZ      = 3'd4;

   // Multiplier operand and product widths
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 34;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Control group into the CORDIC unit
   typedef struct packed {
      logic start;
      logic vectoring;
   } ssc_cordic_ctl_type;

   // Arctangent of 2^-i, Q1.30
   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:  val = 30'd843314857;
         5'd1:  val = 30'd497837829;
         5'd2:  val = 30'd263043837;
         5'd3:  val = 30'd133525159;
         5'd4:  val = 30'd67021687;
         5'd5:  val = 30'd33543516;
         5'd6:  val = 30'd16775851;
         5'd7:  val = 30'd8388437;
         5'd8:  val = 30'd4194283;
         5'd9:  val = 30'd2097149;
         5'd31: val = 30'd0;
         default: val = 30'd1 << (5'd30 - idx);
      endcase
      return val;
   endfunction

endpackage

[hdl/ssc_req_if.sv]
interface ssc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vehicle_x;
   logic signed [31:0] vehicle_y;
   logic signed [15:0] vehicle_yaw;
   logic signed [15:0] speed_x;
   logic signed [15:0] speed_y;
   logic signed [31:0] waypoint_x;
   logic signed [31:0] waypoint_y;
   logic signed [15:0] waypoint_heading;

   modport source (output valid, vehicle_x, vehicle_y, vehicle_yaw, speed_x, speed_y,
                   waypoint_x, waypoint_y, waypoint_heading, input ready);
   modport sink (input valid, vehicle_x, vehicle_y, vehicle_yaw, speed_x, speed_y,
                 waypoint_x, waypoint_y, waypoint_heading, output ready);
endinterface

[hdl/ssc_rsp_if.sv]
interface ssc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] steering_angle;
   logic               status;

   modport source (output valid, steering_angle, status, input ready);
   modport sink (input valid, steering_angle, status, output ready);
endinterface

[hdl/ssc_cordic.sv]
module ssc_cordic #(
   parameter int ITERATIONS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ssc_pkg::ssc_cordic_ctl_type ctl,
   input  logic signed [63:0]        x_init,
   input  logic signed [63:0]        y_init,
   input  logic signed [33:0]        z_init,
   output logic signed [63:0]        x_out,
   output logic signed [63:0]        y_out,
   output logic signed [33:0]        z_out,
   output logic                      done
);
   localparam int STEPS = (ITERATIONS > 32) ? 32 : ITERATIONS;

   logic               busy_ff;
   logic               done_ff;
   logic               vect_ff;
   logic [4:0]         cnt_ff;
   logic signed [63:0] x_ff, y_ff;
   logic signed [33:0] z_ff;
   logic signed [63:0] xs, ys;
   logic signed [33:0] ang;
   logic               sub;

   // One micro-rotation per cycle
   always_comb begin
      xs  = x_ff >>> cnt_ff;
      ys  = y_ff >>> cnt_ff;
      ang = $signed({4'b0, ssc_pkg::atan_entry(cnt_ff)});
      sub = vect_ff ? y_ff[63] : ~z_ff[33];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            vect_ff <= ctl.vectoring;
            x_ff    <= x_init;
            y_ff    <= y_init;
            z_ff    <= z_init;
         end else if (busy_ff) begin
            if (sub) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - ang;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + ang;
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign done  = done_ff;
endmodule

[hdl/ssc_mul.sv]
module ssc_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ssc_pkg::MUL_A_W-1:0]  a,
   input  logic signed [ssc_pkg::MUL_B_W-1:0]  b,
   output logic signed [ssc_pkg::MUL_P_W-1:0]  p,
   output logic                                done
);
   localparam int PW = ssc_pkg::MUL_P_W;
   localparam int BW = ssc_pkg::MUL_B_W;

   logic                 busy_ff;
   logic                 done_ff;
   logic [5:0]           cnt_ff;
   logic signed [PW-1:0] acc_ff;
   logic signed [PW-1:0] ash_ff;
   logic [BW-1:0]        b_ff;
   logic signed [PW-1:0] addend;

   // Sign bit of the multiplier carries negative weight
   always_comb begin
      addend = '0;
      if (b_ff[0])
         addend = (cnt_ff == 6'(BW - 1)) ? -ash_ff : ash_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            acc_ff  <= '0;
            ash_ff  <= PW'(a);
            b_ff    <= b;
         end else if (busy_ff) begin
            acc_ff <= acc_ff + addend;
            ash_ff <= ash_ff <<< 1;
            b_ff   <= b_ff >> 1;
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(BW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign p    = acc_ff;
   assign done = done_ff;
endmodule

[hdl/ssc_sqrt.sv]
module ssc_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic [15:0] root,
   output logic        done
);
   logic        busy_ff;
   logic        done_ff;
   logic [3:0]  cnt_ff;
   logic [31:0] v_ff;
   logic [31:0] r_ff;
   logic [31:0] bit_ff;
   logic [32:0] trial;

   assign trial = {1'b0, r_ff} + {1'b0, bit_ff};

   // One result bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            v_ff    <= value;
            r_ff    <= '0;
            bit_ff  <= 32'h4000_0000;
         end else if (busy_ff) begin
            if ({1'b0, v_ff} >= trial) begin
               v_ff <= v_ff - trial[31:0];
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign root = r_ff[15:0];
   assign done = done_ff;
endmodule

[hdl/stanley_steering_controller_unit.sv]
// One item at a time: a new input beat is taken only in the idle state. The serial 34-step
// multiplier, used seven times per item, takes most of the processing time, the shared CORDIC
// unit and the square root the rest; with a zero denominator the vectoring pass is skipped.
// A stalled result beat adds its stall.
// Reset (synchronous, active high) restores register defaults and clears the previous error.
module stanley_steering_controller_unit #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ssc_req_if.sink     req_bus,
   ssc_rsp_if.source   rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int AW = ssc_pkg::MUL_A_W;
   localparam int BW = ssc_pkg::MUL_B_W;
   localparam int PW = ssc_pkg::MUL_P_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROT, ST_MUL_S, ST_MUL_C, ST_MUL_DOT, ST_MUL_KP, ST_MUL_KD,
      ST_MUL_SX, ST_MUL_SY, ST_SQRT, ST_VEC, ST_DONE
   } state_type;

   state_type          state_ff;
   logic               launched_ff;
   logic [15:0]        kp_ff, ks_ff, kd_ff;
   logic [14:0]        lim_ff;
   logic [9:0]         rate_ff;
   logic signed [15:0] vh_ff, wh_ff, sx_ff, sy_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [33:0] s_ff, c_ff;
   logic signed [51:0] t1_ff;
   logic signed [31:0] cte_ff, last_ff;
   logic signed [32:0] diff_ff;
   logic signed [42:0] dot_ff;
   logic signed [63:0] num_ff;
   logic [31:0]        v2_ff;
   logic [16:0]        den_ff;
   logic signed [15:0] res_ang_ff;
   logic               res_stat_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_ang_ff;
   logic               rsp_stat_ff;

   logic               go;
   logic               neg;
   logic signed [33:0] zw, zr;
   ssc_pkg::ssc_cordic_ctl_type cordic_ctl;
   logic signed [63:0] cx0, cy0, cx, cy;
   logic signed [33:0] cz0, cz;
   logic               cordic_done;
   logic               mul_start, mul_done;
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] mul_p;
   logic               sqrt_start, sqrt_done;
   logic [15:0]        sqrt_root;
   logic signed [52:0] cte_full;
   logic signed [31:0] cte_sat;
   logic [16:0]        den_now;
   logic signed [34:0] z_round;
   logic signed [18:0] ang_sum, lim_pos;
   logic signed [15:0] ang_clamp;

   // Fold the path angle into the CORDIC range
   always_comb begin
      zw  = $signed({{1{wh_ff[15]}}, wh_ff, 17'b0});
      zr  = zw;
      neg = 1'b0;
      if (zw > ssc_pkg::ANG_HALF_PI) begin
         zr  = zw - ssc_pkg::ANG_PI;
         neg = 1'b1;
      end else if (zw < -ssc_pkg::ANG_HALF_PI) begin
         zr  = zw + ssc_pkg::ANG_PI;
         neg = 1'b1;
      end
   end

   // Launch the unit that serves the current state
   always_comb begin
      go = !launched_ff && (state_ff != ST_IDLE) && (state_ff != ST_DONE);
      cordic_ctl.start     = go && (state_ff == ST_ROT || state_ff == ST_VEC);
      cordic_ctl.vectoring = (state_ff == ST_VEC);
      mul_start  = go && (state_ff != ST_ROT) && (state_ff != ST_VEC)
                      && (state_ff != ST_SQRT);
      sqrt_start = go && (state_ff == ST_SQRT);
      if (state_ff == ST_VEC) begin
         cx0 = $signed({31'b0, den_ff, 16'b0});
         cy0 = num_ff;
         cz0 = '0;
      end else begin
         cx0 = ssc_pkg::CORDIC_INV_GAIN;
         cy0 = '0;
         cz0 = zr;
      end
   end

   // Operand select for the multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_S:   begin mul_a = AW'(dx_ff);   mul_b = s_ff; end
         ST_MUL_C:   begin mul_a = AW'(dy_ff);   mul_b = c_ff; end
         ST_MUL_DOT: begin mul_a = AW'(diff_ff); mul_b = $signed({24'b0, rate_ff}); end
         ST_MUL_KP:  begin mul_a = AW'(cte_ff);  mul_b = $signed({18'b0, kp_ff}); end
         ST_MUL_KD:  begin mul_a = AW'(dot_ff);  mul_b = $signed({18'b0, kd_ff}); end
         ST_MUL_SX:  begin mul_a = AW'(sx_ff);   mul_b = BW'(sx_ff); end
         ST_MUL_SY:  begin mul_a = AW'(sy_ff);   mul_b = BW'(sy_ff); end
         default:    begin mul_a = '0;           mul_b = '0; end
      endcase
   end

   // Saturate the cross-track error, form the denominator and the clamped angle
   always_comb begin
      cte_full = 53'(t1_ff) - 53'($signed(mul_p[PW-1:30]));
      if (cte_full > 53'sd2147483647)
         cte_sat = 32'sh7FFF_FFFF;
      else if (cte_full < -53'sd2147483648)
         cte_sat = 32'sh8000_0000;
      else
         cte_sat = cte_full[31:0];
      den_now = {1'b0, ks_ff} + {1'b0, sqrt_root};
      z_round = 35'(cz) + 35'sd65536;
      ang_sum = 19'($signed(z_round[34:17])) + 19'(wh_ff) - 19'(vh_ff);
      lim_pos = $signed({4'b0, lim_ff});
      if (ang_sum > lim_pos)
         ang_clamp = lim_pos[15:0];
      else if (ang_sum < -lim_pos)
         ang_clamp = 16'(-lim_pos);
      else
         ang_clamp = ang_sum[15:0];
   end

   ssc_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock(clock), .reset(reset), .ctl(cordic_ctl),
      .x_init(cx0), .y_init(cy0), .z_init(cz0),
      .x_out(cx), .y_out(cy), .z_out(cz), .done(cordic_done)
   );

   ssc_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(mul_a), .b(mul_b), .p(mul_p), .done(mul_done)
   );

   ssc_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start),
      .value(v2_ff), .root(sqrt_root), .done(sqrt_done)
   );

   // Sequencer, configuration registers and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         kp_ff        <= 16'd256;
         ks_ff        <= 16'd256;
         kd_ff        <= 16'd0;
         lim_ff       <= 15'd4289;
         rate_ff      <= 10'd100;
      end else begin
         if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
               ssc_pkg::REG_PROPORTIONAL_GAIN: kp_ff   <= pwdata[15:0];
               ssc_pkg::REG_SOFTENING_GAIN:    ks_ff   <= pwdata[15:0];
               ssc_pkg::REG_DERIVATIVE_GAIN:   kd_ff   <= pwdata[15:0];
               ssc_pkg::REG_STEERING_LIMIT:    lim_ff  <= pwdata[14:0];
               ssc_pkg::REG_LOOP_RATE_HZ:      rate_ff <= pwdata[9:0];
               default: ;
            endcase
         end
         // Raise the result beat from the done state, drop it once taken
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_bus.ready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_bus.ready)
            rsp_valid_ff <= 1'b0;
         // Hold the launched mark until the active unit reports done
         if (go)
            launched_ff <= 1'b1;
         else if (cordic_done || mul_done || sqrt_done)
            launched_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  vh_ff    <= req_bus.vehicle_yaw;
                  wh_ff    <= req_bus.waypoint_heading;
                  sx_ff    <= req_bus.speed_x;
                  sy_ff    <= req_bus.speed_y;
                  dx_ff    <= 33'(req_bus.vehicle_x) - 33'(req_bus.waypoint_x);
                  dy_ff    <= 33'(req_bus.vehicle_y) - 33'(req_bus.waypoint_y);
                  state_ff <= ST_ROT;
               end
            end
            ST_ROT: begin
               if (cordic_done) begin
                  s_ff     <= neg ? -cy[33:0] : cy[33:0];
                  c_ff     <= neg ? -cx[33:0] : cx[33:0];
                  state_ff <= ST_MUL_S;
               end
            end
            ST_MUL_S: begin
               if (mul_done) begin
                  t1_ff    <= mul_p[PW-1:30];
                  state_ff <= ST_MUL_C;
               end
            end
            ST_MUL_C: begin
               if (mul_done) begin
                  cte_ff   <= cte_sat;
                  diff_ff  <= 33'(cte_sat) - 33'(last_ff);
                  last_ff  <= cte_sat;
                  state_ff <= ST_MUL_DOT;
               end
            end
            ST_MUL_DOT: begin
               if (mul_done) begin
                  dot_ff   <= mul_p[42:0];
                  state_ff <= ST_MUL_KP;
               end
            end
            ST_MUL_KP: begin
               if (mul_done) begin
                  num_ff   <= mul_p[63:0];
                  state_ff <= ST_MUL_KD;
               end
            end
            ST_MUL_KD: begin
               if (mul_done) begin
                  num_ff   <= num_ff + mul_p[63:0];
                  state_ff <= ST_MUL_SX;
               end
            end
            ST_MUL_SX: begin
               if (mul_done) begin
                  v2_ff    <= mul_p[31:0];
                  state_ff <= ST_MUL_SY;
               end
            end
            ST_MUL_SY: begin
               if (mul_done) begin
                  v2_ff    <= v2_ff + mul_p[31:0];
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (sqrt_done) begin
                  den_ff <= den_now;
                  if (den_now == 17'd0) begin
                     res_ang_ff  <= '0;
                     res_stat_ff <= 1'b1;
                     state_ff    <= ST_DONE;
                  end else begin
                     state_ff <= ST_VEC;
                  end
               end
            end
            ST_VEC: begin
               if (cordic_done) begin
                  res_ang_ff  <= ang_clamp;
                  res_stat_ff <= 1'b0;
                  state_ff    <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_ang_ff   <= res_ang_ff;
                  rsp_stat_ff  <= res_stat_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Register read back
   always_comb begin
      unique case (paddr[4:2])
         ssc_pkg::REG_PROPORTIONAL_GAIN: prdata = {16'b0, kp_ff};
         ssc_pkg::REG_SOFTENING_GAIN:    prdata = {16'b0, ks_ff};
         ssc_pkg::REG_DERIVATIVE_GAIN:   prdata = {16'b0, kd_ff};
         ssc_pkg::REG_STEERING_LIMIT:    prdata = {17'b0, lim_ff};
         ssc_pkg::REG_LOOP_RATE_HZ:      prdata = {22'b0, rate_ff};
         default:                        prdata = '0;
      endcase
   end

   assign pready                 = 1'b1;
   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.steering_angle = rsp_ang_ff;
   assign rsp_bus.status         = rsp_stat_ff;
endmodule

[hdl/ssc_checker.sv]
`include "assert_macros.svh"

module ssc_props (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_steering_angle,
   input logic               rsp_status
);
   logic        req_beat;
   logic        rsp_stall;
   logic        rsp_invalid;
   logic [16:0] rsp_payload;

   assign req_beat    = req_valid && req_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_invalid = rsp_valid && rsp_status;
   assign rsp_payload = {rsp_steering_angle, rsp_status};

   // An invalid result always carries a zero angle
   `SSC_ASSERT(a_inv_zero, rsp_invalid |-> rsp_steering_angle == '0, "nonzero invalid angle")

   // A waiting result beat holds until taken
   `SSC_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled beat changed")

   // The block goes busy right after taking an input beat
   `SSC_ASSERT(a_busy_after_accept, req_beat |=> !req_ready, "ready high after an input beat")
endmodule

bind stanley_steering_controller_unit ssc_props u_ssc_props (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_steering_angle(rsp_bus.steering_angle),
   .rsp_status(rsp_bus.status)
);

[bench/ssc_checker.sv]
// Watches the request, response and register traffic of the steering unit,
// predicts every steering command and compares it with what comes back.
module ssc_checker (
   input  logic        clock,
   input  logic        reset,
   ssc_req_if          req_bus,
   ssc_rsp_if          rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatch_count,
   output int          steer_pending,
   output int          steer_checked,
   output int          invalid_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     STEPS      = 16;
   localparam longint PI_Q30     = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint INV_GAIN   = 64'sd652032874;

   typedef struct {
      logic signed [15:0] steering_angle;
      logic               status;
   } steer_cmd_type;

   // Arctangent of 2^-i, Q1.30
   const longint arctan_q30 [32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};

   logic [15:0]   kp, ks, kd;
   logic [14:0]   limit_q13;
   logic [9:0]    rate_hz;
   longint        prev_cte;
   steer_cmd_type steer_queue [$];

   // Rotation mode: sine and cosine of a Q2.13 heading, Q1.30
   task automatic rotate_heading(input longint head, output longint s, output longint c);
      longint z, x, y, xs, ys;
      bit     flip;
      z = head * 131072;
      x = INV_GAIN;
      y = 0;
      flip = 0;
      if (z > HALF_PI_Q30) begin
         z -= PI_Q30;
         flip = 1;
      end else if (z < -HALF_PI_Q30) begin
         z += PI_Q30;
         flip = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= arctan_q30[i];
         end else begin
            x += ys; y -= xs; z += arctan_q30[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   // Vectoring mode: angle of (x, y) for x > 0, Q1.30
   function automatic longint vector_angle(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y < 0) begin
            x -= ys; y += xs; z -= arctan_q30[i];
         end else begin
            x += ys; y -= xs; z += arctan_q30[i];
         end
      end
      return z;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Work out one steering command and advance the stored error
   task automatic predict_steer(output steer_cmd_type cmd);
      longint vx, vy, vh, sx, sy, wx, wy, wh;
      longint s, c, cte, rate_term, num, den, ang;
      vx = req_bus.vehicle_x;       vy = req_bus.vehicle_y;
      vh = req_bus.vehicle_yaw;
      sx = req_bus.speed_x;         sy = req_bus.speed_y;
      wx = req_bus.waypoint_x;      wy = req_bus.waypoint_y;
      wh = req_bus.waypoint_heading;
      rotate_heading(wh, s, c);
      cte = ((s * (vx - wx)) >>> 30) - ((c * (vy - wy)) >>> 30);
      if (cte > 64'sd2147483647) cte = 64'sd2147483647;
      if (cte < -64'sd2147483648) cte = -64'sd2147483648;
      rate_term = (cte - prev_cte) * longint'(rate_hz);
      prev_cte = cte;
      den = longint'(ks) + longint'(floor_sqrt(longint'(sx * sx + sy * sy)));
      if (den == 0) begin
         cmd.steering_angle = '0;
         cmd.status = 1'b1;
      end else begin
         num = longint'(kp) * cte + longint'(kd) * rate_term;
         ang = ((vector_angle(den * 65536, num) + 65536) >>> 17) + wh - vh;
         if (ang > longint'(limit_q13)) ang = limit_q13;
         if (ang < -longint'(limit_q13)) ang = -longint'(limit_q13);
         cmd.steering_angle = ang[15:0];
         cmd.status = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      steer_cmd_type want;
      if (reset) begin
         kp = 16'd256;
         ks = 16'd256;
         kd = 16'd0;
         limit_q13 = 15'd4289;
         rate_hz = 10'd100;
         prev_cte = 0;
         steer_queue.delete();
         mismatch_count = 0;
         steer_checked = 0;
         invalid_seen = 0;
      end else begin
         // track register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               ssc_pkg::REG_PROPORTIONAL_GAIN: kp = pwdata[15:0];
               ssc_pkg::REG_SOFTENING_GAIN:    ks = pwdata[15:0];
               ssc_pkg::REG_DERIVATIVE_GAIN:   kd = pwdata[15:0];
               ssc_pkg::REG_STEERING_LIMIT:    limit_q13 = pwdata[14:0];
               ssc_pkg::REG_LOOP_RATE_HZ:      rate_hz = pwdata[9:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_steer(want);
            steer_queue.push_back(want);
         end
         // compare each response beat with the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (steer_queue.size() == 0) begin
               $error("unexpected response beat: steering_angle %0d status %0d",
                      rsp_bus.steering_angle, rsp_bus.status);
               mismatch_count++;
            end else begin
               want = steer_queue.pop_front();
               steer_checked++;
               if (want.status) invalid_seen++;
               if (rsp_bus.steering_angle !== want.steering_angle) begin
                  $error("steering_angle: expected %0d, got %0d",
                         want.steering_angle, rsp_bus.steering_angle);
                  mismatch_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  mismatch_count++;
               end
            end
         end
      end
      steer_pending = steer_queue.size();
   end

endmodule

[bench/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 320;
   localparam int PHASE_ITEMS  = 375;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          mismatch_count, steer_pending, steer_checked, invalid_seen;
   int          send_gap_pct = 0;
   int          stall_pct = 0;
   int          quiet_cycles;
   int          items_sent = 0;

   ssc_req_if req_bus ();
   ssc_rsp_if rsp_bus ();

   stanley_steering_controller_unit dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready));

   ssc_checker steer_check (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .mismatch_count(mismatch_count),
      .steer_pending(steer_pending), .steer_checked(steer_checked),
      .invalid_seen(invalid_seen));

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.vehicle_x = '0;
      req_bus.vehicle_y = '0;
      req_bus.vehicle_yaw = '0;
      req_bus.speed_x = '0;
      req_bus.speed_y = '0;
      req_bus.waypoint_x = '0;
      req_bus.waypoint_y = '0;
      req_bus.waypoint_heading = '0;
      rsp_bus.ready = 1'b0;
   end

   // Random back-pressure on the response side
   always @(posedge clock)
      rsp_bus.ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);

   // Drop the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Two-phase register write, starting at a clock edge
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Drop the request, wait for every outstanding command, then load a full register set
   task automatic load_gains(input logic [15:0] p, input logic [15:0] s, input logic [15:0] d,
                             input logic [14:0] lim, input logic [9:0] rate);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (steer_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write(ssc_pkg::REG_PROPORTIONAL_GAIN, 32'(p));
      csr_write(ssc_pkg::REG_SOFTENING_GAIN, 32'(s));
      csr_write(ssc_pkg::REG_DERIVATIVE_GAIN, 32'(d));
      csr_write(ssc_pkg::REG_STEERING_LIMIT, 32'(lim));
      csr_write(ssc_pkg::REG_LOOP_RATE_HZ, 32'(rate));
   endtask

   // Send one tick, holding valid until the beat is taken
   task automatic send_tick(input logic signed [31:0] vx, input logic signed [31:0] vy,
                            input logic signed [15:0] vh, input logic signed [15:0] sx,
                            input logic signed [15:0] sy, input logic signed [31:0] wx,
                            input logic signed [31:0] wy, input logic signed [15:0] wh);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.vehicle_x <= vx;
      req_bus.vehicle_y <= vy;
      req_bus.vehicle_yaw <= vh;
      req_bus.speed_x <= sx;
      req_bus.speed_y <= sy;
      req_bus.waypoint_x <= wx;
      req_bus.waypoint_y <= wy;
      req_bus.waypoint_heading <= wh;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   function automatic logic signed [15:0] any_heading();
      return 16'($signed($urandom_range(51472)) - 25736);
   endfunction

   // Mostly a vehicle tracking close to its waypoint, now and then raw noise
   task automatic send_random_tick();
      logic signed [31:0] wx, wy;
      logic signed [15:0] wh;
      int                 near;
      wx = $urandom;
      wy = $urandom;
      wh = any_heading();
      if ($urandom_range(99) < 80) begin
         near = 1 << $urandom_range(20, 8);
         send_tick(wx + $signed($urandom_range(2 * near)) - near,
                   wy + $signed($urandom_range(2 * near)) - near,
                   16'(wh + $signed($urandom_range(4000)) - 2000),
                   ($urandom_range(9) == 0) ? 16'sd0
                                            : 16'($signed($urandom_range(8000)) - 4000),
                   ($urandom_range(9) == 0) ? 16'sd0
                                            : 16'($signed($urandom_range(2000)) - 1000),
                   wx, wy, wh);
      end else begin
         send_tick($urandom, $urandom, any_heading(), 16'($urandom), 16'($urandom),
                   wx, wy, wh);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, position and heading extremes
      send_tick(0, 0, 0, 0, 0, 0, 0, 0);
      send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd25736, 16'sd32767, 16'sd32767,
                32'sh8000_0000, 32'sh8000_0000, -16'sd25736);
      send_tick(32'sh8000_0000, 32'sh8000_0000, -16'sd25736, -16'sd32768, -16'sd32768,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd25736);
      send_tick(32'sd65536, -32'sd65536, 16'sd0, 16'sd256, 16'sd0, 0, 0, 16'sd12868);
      send_tick(-32'sd131072, 32'sd65536, 16'sd100, 16'sd0, -16'sd512, 0, 0, -16'sd12869);

      // zero softening with high gains and a limit beyond range
      load_gains(16'hFFFF, 16'd0, 16'hFFFF, 15'h7FFF, 10'd1000);
      send_tick(32'sd70000, 32'sd5000, 16'sd0, 16'sd0, 16'sd0, 0, 0, 16'sd0);
      send_tick(-32'sd70000, 32'sd5000, 16'sd25736, 16'sd1, 16'sd0, 0, 0, -16'sd25736);
      send_tick(32'sh7FFF_FFFF, 0, -16'sd25736, 16'sd0, -16'sd1, 32'sh8000_0000, 0,
                16'sd25736);
      send_tick(0, 0, 0, 16'sd0, 16'sd0, 0, 0, 0);
      send_tick(32'sd12345, -32'sd999, 16'sd3000, -16'sd32768, 16'sd32767, 0, 0, -16'sd3000);

      // zero gains and zero limit, then moderate gains, both with a stopped loop clock
      load_gains(16'd0, 16'hFFFF, 16'd0, 15'd0, 10'd0);
      send_tick(32'sd65536, 32'sd65536, 16'sd500, 16'sd100, 16'sd100, 0, 0, -16'sd500);
      send_tick(-32'sd65536, 0, 0, 16'sd0, 16'sd0, 0, 0, 16'sd8000);
      load_gains(16'd512, 16'd128, 16'd64, 15'd25736, 10'd0);
      send_tick(32'sd300000, 32'sd20000, -16'sd1000, 16'sd2000, 16'sd0, 0, 0, 16'sd2000);
      send_tick(-32'sd300000, 32'sd20000, 16'sd1000, 16'sd0, 16'sd2000, 0, 0, 16'sd9000);

      // random phases under each idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         load_gains(16'($urandom_range(2048)),
                    16'(($urandom_range(3) == 0) ? 0 : $urandom_range(1024)),
                    16'($urandom_range(512)), 15'($urandom_range(25736, 500)),
                    10'($urandom_range(1000, 1)));
         case (phase)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 74; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 74; end
            default: begin send_gap_pct = 33; stall_pct = 33; end
         endcase
         repeat (PHASE_ITEMS) send_random_tick();
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end

      // drain
      while (steer_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d ticks over four idling patterns and eight register sets;", items_sent);
      $display("checked %0d commands, %0d of them flagged invalid.", steer_checked,
               invalid_seen);
      if (mismatch_count == 0 && steer_pending == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/ssc_pkg.sv
hdl/ssc_req_if.sv
hdl/ssc_rsp_if.sv
hdl/ssc_cordic.sv
hdl/ssc_mul.sv
hdl/ssc_sqrt.sv
hdl/stanley_steering_controller_unit.sv
hdl/ssc_checker.sv
bench/ssc_checker.sv
bench/testbench.sv
